// ===== rtl/selective_repeat_receive_window_assert.svh =====
// Assertion macros shared by the receive window modules.
// Needs nothing else; files that check their own logic include it.
`ifndef SELECTIVE_REPEAT_RECEIVE_WINDOW_ASSERT_SVH
`define SELECTIVE_REPEAT_RECEIVE_WINDOW_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define SRRW_ASSERT_IMPL(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("srrw assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define SRRW_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("srrw assertion failed");
`else
`define SRRW_ASSERT_IMPL(name, clk, rst_n, pre, post)
`define SRRW_ASSERT_NEXT(name, clk, rst_n, pre, post)
`endif

`endif

// ===== rtl/srrw_pkg.sv =====
// Shared types and constants of the selective-repeat receive window.
// No dependencies; every file but the RAM and the assert header imports it.
package srrw_pkg;

    localparam int unsigned WINDOW_DEFAULT = 2;
    localparam int unsigned MAX_RES        = 2;

    localparam int unsigned TAG_W      = 7;
    localparam int unsigned LEN_W      = 11;
    localparam int unsigned SEQ_W      = 32;
    localparam int unsigned ELAPSED_W  = 32;
    localparam int unsigned RETRY_W    = 8;
    localparam int unsigned KIND_W     = 2;
    localparam int unsigned RES_CNT_W  = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELIVER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FAIL    = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PACKET_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RETRIES      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_PAYLOAD_LEN = 2'd3;

    // Reset values
    localparam logic [SEQ_W-1:0]     PACKET_COUNT_RESET = '0;
    localparam logic [ELAPSED_W-1:0] TIMEOUT_RESET      = 32'd2000000;
    localparam logic [RETRY_W-1:0]   MAX_RETRIES_RESET  = 8'd14;
    localparam logic [LEN_W-1:0]     PAYLOAD_LEN_RESET  = 11'd1398;
    localparam logic [RETRY_W-1:0]   RETRY_RESET        = 8'd1;

    typedef struct packed {
        logic start;
        logic arr_decode;
        logic arr_fill;
        logic scan_init;
        logic scan_eval;
        logic dlv_step;
        logic push_fail;
        logic out_pop;
    } srrw_cmd_t;

    typedef struct packed {
        logic                 failed;
        logic                 complete;
        logic                 scan_last;
        logic                 fail_hit;
        logic                 dlv_ok;
        logic                 out_last;
        logic [RES_CNT_W-1:0] res_count;
    } srrw_status_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SEQ_W-1:0]  seq_number;
        logic [TAG_W-1:0]  request_tag;
        logic [LEN_W-1:0]  deliver_len;
        logic              done_res;
    } srrw_result_t;

endpackage

// ===== rtl/srrw_item_if.sv =====
// Input item channel: valid/ready handshake with the arrival payload.
// Depends on srrw_pkg.
interface srrw_item_if;
    import srrw_pkg::*;

    logic             valid;
    logic             ready;
    logic             operation;
    logic [TAG_W-1:0] tag;
    logic [LEN_W-1:0] length;

    modport source (output valid, output operation, output tag, output length, input ready);
    modport sink   (input valid, input operation, input tag, input length, output ready);
endinterface

// ===== rtl/srrw_result_if.sv =====
// Result channel: valid/ready handshake with request, delivery and fail results.
// Depends on srrw_pkg.
interface srrw_result_if;
    import srrw_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [SEQ_W-1:0]  seq_number;
    logic [TAG_W-1:0]  request_tag;
    logic [LEN_W-1:0]  deliver_len;
    logic              last;
    logic              done_res;

    modport source (output valid, output kind, output seq_number, output request_tag,
                    output deliver_len, output last, output done_res, input ready);
    modport sink   (input valid, input kind, input seq_number, input request_tag,
                    input deliver_len, input last, input done_res, output ready);
endinterface

// ===== rtl/srrw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srrw_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 2,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/srrw_ctrl.sv =====
// Sequencer of the receive window: dispatches each item, steps the slot scan,
// the delivery loop and the result transfers. Depends on srrw_pkg and the assert header.
`include "selective_repeat_receive_window_assert.svh"

module srrw_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_op,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  srrw_pkg::srrw_status_t status,
    output srrw_pkg::srrw_cmd_t    cmd
);
    import srrw_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_ARR_DEC  = 3'd1;
    localparam logic [2:0] S_ARR_FILL = 3'd2;
    localparam logic [2:0] S_SCAN_RD  = 3'd3;
    localparam logic [2:0] S_SCAN_EV  = 3'd4;
    localparam logic [2:0] S_DELIVER  = 3'd5;
    localparam logic [2:0] S_FAIL     = 3'd6;
    localparam logic [2:0] S_OUT      = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.start = 1'b1;
                    if (status.failed)
                        state_next = S_FAIL;
                    else if (status.complete)
                        state_next = S_IDLE;
                    else if (in_op)
                        state_next = S_ARR_DEC;
                    else
                        state_next = S_SCAN_RD;
                end
            end
            S_ARR_DEC:
            begin
                cmd.arr_decode = 1'b1;
                state_next     = S_ARR_FILL;
            end
            S_ARR_FILL:
            begin
                cmd.arr_fill = 1'b1;
                state_next   = S_DELIVER;
            end
            S_SCAN_RD:
            begin
                cmd.scan_init = 1'b1;
                state_next    = S_SCAN_EV;
            end
            S_SCAN_EV:
            begin
                cmd.scan_eval = 1'b1;
                if (status.fail_hit)
                    state_next = S_OUT;
                else if (status.scan_last)
                    state_next = S_DELIVER;
            end
            S_DELIVER:
            begin
                if (status.dlv_ok)
                    cmd.dlv_step = 1'b1;
                else if (status.res_count != '0)
                    state_next = S_OUT;
                else
                    state_next = S_IDLE;
            end
            S_FAIL:
            begin
                cmd.push_fail = 1'b1;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    if (status.out_last)
                        state_next = S_IDLE;
                    else
                        cmd.out_pop = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    `SRRW_ASSERT_IMPL(a_one_side_open, clk, rst_n, 1'b1, !(in_ready && out_valid))
    `SRRW_ASSERT_NEXT(a_fail_goes_out, clk, rst_n, (state_reg == S_SCAN_EV) && status.fail_hit, state_reg == S_OUT)
    `SRRW_ASSERT_NEXT(a_empty_back_idle, clk, rst_n, (state_reg == S_DELIVER) && !status.dlv_ok && (status.res_count == '0), state_reg == S_IDLE)
endmodule

// ===== rtl/srrw_datapath.sv =====
// Window state, configuration registers, slot timer RAM and result buffer.
// Depends on srrw_pkg, srrw_ram and the assert header.
`include "selective_repeat_receive_window_assert.svh"

module srrw_datapath #(
    parameter int unsigned WINDOW = srrw_pkg::WINDOW_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [srrw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [srrw_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [srrw_pkg::TAG_W-1:0]          in_tag,
    input  logic [srrw_pkg::LEN_W-1:0]          in_length,
    input  srrw_pkg::srrw_cmd_t                 cmd,
    output srrw_pkg::srrw_status_t              status,
    output srrw_pkg::srrw_result_t              res
);
    import srrw_pkg::*;

    localparam int unsigned TAG_MOD  = 3 * WINDOW;
    localparam int unsigned BASE_W   = $clog2(TAG_MOD);
    localparam int unsigned IDX_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned TAG_VALS = 1 << TAG_W;

    // Configuration
    logic [SEQ_W-1:0]     packet_count_reg;
    logic [ELAPSED_W-1:0] timeout_reg;
    logic [RETRY_W-1:0]   max_retries_reg;
    logic [LEN_W-1:0]     full_len_reg;

    // Window state
    logic [SEQ_W-1:0]   next_seq_reg,  next_seq_next;
    logic [BASE_W-1:0]  base_reg,      base_next;
    logic [IDX_W-1:0]   head_reg,      head_next;
    logic [WINDOW-1:0]  filled_reg,    filled_next;
    logic [WINDOW-1:0]  requested_reg, requested_next;
    logic [RETRY_W-1:0] retry_reg,     retry_next;
    logic [LEN_W-1:0]   last_len_reg,  last_len_next;
    logic               failed_reg,    failed_next;

    // Latched item payload
    logic [TAG_W-1:0] tag_reg, tag_next;
    logic [LEN_W-1:0] len_reg, len_next;

    // Arrival decode
    logic             arr_hit_reg,  arr_hit_next;
    logic [IDX_W-1:0] arr_off_reg,  arr_off_next;
    logic [IDX_W-1:0] arr_phys_reg, arr_phys_next;

    // Slot scan
    logic [IDX_W-1:0]  scan_i_reg,   scan_i_next;
    logic [IDX_W-1:0]  scan_p_reg,   scan_p_next;
    logic [BASE_W-1:0] scan_tag_reg, scan_tag_next;
    logic [SEQ_W:0]    scan_seq_reg, scan_seq_next;

    // Result buffer
    srrw_result_t         res_buf_reg [MAX_RES];
    srrw_result_t         res_buf_next [MAX_RES];
    logic [RES_CNT_W-1:0] res_count_reg, res_count_next;
    logic                 rd_reg, rd_next;

    // Combinational helpers
    logic [BASE_W-1:0]    tag_lut [TAG_VALS];
    logic [BASE_W:0]      arr_sum, arr_off_full;
    logic [IDX_W:0]       arr_phys_sum;
    logic [SEQ_W:0]       fill_seq;
    logic                 fill_ok, fill_is_last;
    logic [ELAPSED_W-1:0] ram_rdata, elapsed_aged, elapsed_new;
    logic [IDX_W-1:0]     ram_raddr, scan_p_wrap;
    logic                 slot_active, consider, timed_out, retry_ok;
    logic                 is_new, is_retry, fail_cond;
    logic [SEQ_W-1:0]     seq_inc;
    logic                 dlv_done;
    srrw_result_t         fail_res;

    // Tag reduction table: tag modulo the tag space
    for (genvar v = 0; v < TAG_VALS; v++)
    begin : g_tag_lut
        assign tag_lut[v] = BASE_W'(v % TAG_MOD);
    end

    // Arrival offset from the window base, then its physical slot
    always_comb
    begin
        arr_sum      = {1'b0, tag_lut[tag_reg]} + (BASE_W + 1)'(TAG_MOD) - {1'b0, base_reg};
        arr_off_full = (arr_sum >= (BASE_W + 1)'(TAG_MOD)) ? arr_sum - (BASE_W + 1)'(TAG_MOD)
                                                           : arr_sum;
        arr_phys_sum = {1'b0, head_reg} + {1'b0, IDX_W'(arr_off_full)};
        if (arr_phys_sum >= (IDX_W + 1)'(WINDOW))
            arr_phys_sum = arr_phys_sum - (IDX_W + 1)'(WINDOW);
    end

    assign fill_seq     = {1'b0, next_seq_reg} + (SEQ_W + 1)'(arr_off_reg);
    assign fill_ok      = fill_seq < {1'b0, packet_count_reg};
    assign fill_is_last = (fill_seq + (SEQ_W + 1)'(1)) == {1'b0, packet_count_reg};

    // Slot evaluation: age first, then decide
    assign slot_active  = requested_reg[scan_p_reg] && !filled_reg[scan_p_reg];
    assign elapsed_aged = (slot_active && (ram_rdata != '1)) ? ram_rdata + ELAPSED_W'(1)
                                                              : ram_rdata;
    assign consider     = (res_count_reg < RES_CNT_W'(MAX_RES)) && !filled_reg[scan_p_reg]
                          && (scan_seq_reg < {1'b0, packet_count_reg});
    assign timed_out    = elapsed_aged >= timeout_reg;
    assign retry_ok     = retry_reg <= max_retries_reg;
    assign is_new       = consider && !requested_reg[scan_p_reg];
    assign is_retry     = consider && requested_reg[scan_p_reg] && timed_out && retry_ok;
    assign fail_cond    = consider && requested_reg[scan_p_reg] && !(timed_out && retry_ok)
                          && !retry_ok;
    assign elapsed_new  = (is_new || is_retry) ? '0 : elapsed_aged;
    assign scan_p_wrap  = (scan_p_reg == IDX_W'(WINDOW - 1)) ? '0 : scan_p_reg + IDX_W'(1);
    assign ram_raddr    = cmd.scan_eval ? scan_p_wrap : head_reg;

    srrw_ram #(
        .WIDTH (ELAPSED_W),
        .DEPTH (WINDOW)
    ) u_elapsed_ram (
        .clk   (clk),
        .we    (cmd.scan_eval),
        .waddr (scan_p_reg),
        .wdata (elapsed_new),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign seq_inc  = next_seq_reg + SEQ_W'(1);
    assign dlv_done = (seq_inc == packet_count_reg);

    always_comb
    begin
        fail_res             = '0;
        fail_res.kind        = KIND_FAIL;
        fail_res.seq_number  = next_seq_reg;
    end

    always_comb
    begin
        next_seq_next  = next_seq_reg;
        base_next      = base_reg;
        head_next      = head_reg;
        filled_next    = filled_reg;
        requested_next = requested_reg;
        retry_next     = retry_reg;
        last_len_next  = last_len_reg;
        failed_next    = failed_reg;
        tag_next       = tag_reg;
        len_next       = len_reg;
        arr_hit_next   = arr_hit_reg;
        arr_off_next   = arr_off_reg;
        arr_phys_next  = arr_phys_reg;
        scan_i_next    = scan_i_reg;
        scan_p_next    = scan_p_reg;
        scan_tag_next  = scan_tag_reg;
        scan_seq_next  = scan_seq_reg;
        res_buf_next   = res_buf_reg;
        res_count_next = res_count_reg;
        rd_next        = rd_reg;

        if (cmd.start)
        begin
            tag_next       = in_tag;
            len_next       = in_length;
            res_count_next = '0;
            rd_next        = 1'b0;
        end

        if (cmd.arr_decode)
        begin
            arr_hit_next  = arr_off_full < (BASE_W + 1)'(WINDOW);
            arr_off_next  = IDX_W'(arr_off_full);
            arr_phys_next = IDX_W'(arr_phys_sum);
        end

        if (cmd.arr_fill && arr_hit_reg && fill_ok)
        begin
            filled_next[arr_phys_reg] = 1'b1;
            if (fill_is_last)
                last_len_next = len_reg;
        end

        if (cmd.scan_init)
        begin
            scan_i_next   = '0;
            scan_p_next   = head_reg;
            scan_tag_next = base_reg;
            scan_seq_next = {1'b0, next_seq_reg};
        end

        if (cmd.scan_eval)
        begin
            if (is_new)
            begin
                requested_next[scan_p_reg] = 1'b1;
                retry_next                 = RETRY_RESET;
            end
            if (is_retry && (retry_reg != '1))
                retry_next = retry_reg + RETRY_W'(1);
            if (is_new || is_retry)
            begin
                res_buf_next[res_count_reg[0]]             = '0;
                res_buf_next[res_count_reg[0]].kind        = KIND_REQUEST;
                res_buf_next[res_count_reg[0]].seq_number  = scan_seq_reg[SEQ_W-1:0];
                res_buf_next[res_count_reg[0]].request_tag = TAG_W'(scan_tag_reg);
                res_count_next                             = res_count_reg + RES_CNT_W'(1);
            end
            // Drop the requests of this tick and report the failure alone
            if (fail_cond)
            begin
                failed_next     = 1'b1;
                res_buf_next[0] = fail_res;
                res_count_next  = RES_CNT_W'(1);
            end
            scan_i_next   = scan_i_reg + IDX_W'(1);
            scan_p_next   = scan_p_wrap;
            scan_tag_next = (scan_tag_reg == BASE_W'(TAG_MOD - 1)) ? '0
                                                                   : scan_tag_reg + BASE_W'(1);
            scan_seq_next = scan_seq_reg + (SEQ_W + 1)'(1);
        end

        if (cmd.dlv_step)
        begin
            res_buf_next[res_count_reg[0]]             = '0;
            res_buf_next[res_count_reg[0]].kind        = KIND_DELIVER;
            res_buf_next[res_count_reg[0]].seq_number  = next_seq_reg;
            res_buf_next[res_count_reg[0]].deliver_len = dlv_done ? last_len_reg : full_len_reg;
            res_buf_next[res_count_reg[0]].done_res    = dlv_done;
            res_count_next                             = res_count_reg + RES_CNT_W'(1);
            // Shift the window: retire the head slot and advance base and head
            next_seq_next            = seq_inc;
            filled_next[head_reg]    = 1'b0;
            requested_next[head_reg] = 1'b0;
            head_next = (head_reg == IDX_W'(WINDOW - 1)) ? '0 : head_reg + IDX_W'(1);
            base_next = (base_reg == BASE_W'(TAG_MOD - 1)) ? '0 : base_reg + BASE_W'(1);
        end

        if (cmd.push_fail)
        begin
            res_buf_next[0] = fail_res;
            res_count_next  = RES_CNT_W'(1);
        end

        if (cmd.out_pop)
            rd_next = !rd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packet_count_reg <= PACKET_COUNT_RESET;
            timeout_reg      <= TIMEOUT_RESET;
            max_retries_reg  <= MAX_RETRIES_RESET;
            full_len_reg     <= PAYLOAD_LEN_RESET;
            next_seq_reg     <= '0;
            base_reg         <= '0;
            head_reg         <= '0;
            filled_reg       <= '0;
            requested_reg    <= '0;
            retry_reg        <= RETRY_RESET;
            last_len_reg     <= PAYLOAD_LEN_RESET;
            failed_reg       <= 1'b0;
            res_count_reg    <= '0;
            rd_reg           <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_PACKET_COUNT:     packet_count_reg <= cfg_data[SEQ_W-1:0];
                    REG_TIMEOUT_TICKS:    timeout_reg      <= cfg_data[ELAPSED_W-1:0];
                    REG_MAX_RETRIES:      max_retries_reg  <= cfg_data[RETRY_W-1:0];
                    REG_FULL_PAYLOAD_LEN: full_len_reg     <= cfg_data[LEN_W-1:0];
                    default:              ;
                endcase
            end
            next_seq_reg  <= next_seq_next;
            base_reg      <= base_next;
            head_reg      <= head_next;
            filled_reg    <= filled_next;
            requested_reg <= requested_next;
            retry_reg     <= retry_next;
            last_len_reg  <= last_len_next;
            failed_reg    <= failed_next;
            res_count_reg <= res_count_next;
            rd_reg        <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg      <= tag_next;
        len_reg      <= len_next;
        arr_hit_reg  <= arr_hit_next;
        arr_off_reg  <= arr_off_next;
        arr_phys_reg <= arr_phys_next;
        scan_i_reg   <= scan_i_next;
        scan_p_reg   <= scan_p_next;
        scan_tag_reg <= scan_tag_next;
        scan_seq_reg <= scan_seq_next;
        res_buf_reg  <= res_buf_next;
    end

    always_comb
    begin
        status.failed    = failed_reg;
        status.complete  = next_seq_reg >= packet_count_reg;
        status.scan_last = scan_i_reg == IDX_W'(WINDOW - 1);
        status.fail_hit  = fail_cond;
        status.dlv_ok    = (res_count_reg < RES_CNT_W'(MAX_RES))
                           && (next_seq_reg < packet_count_reg) && filled_reg[head_reg];
        status.out_last  = {1'b0, rd_reg} == (res_count_reg - RES_CNT_W'(1));
        status.res_count = res_count_reg;
    end

    assign res = res_buf_reg[rd_reg];

    `SRRW_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, res_count_reg <= RES_CNT_W'(MAX_RES))
    `SRRW_ASSERT_NEXT(a_failed_sticky, clk, rst_n, failed_reg, failed_reg)
    `SRRW_ASSERT_IMPL(a_fail_alone, clk, rst_n, res_count_reg == RES_CNT_W'(MAX_RES), (res_buf_reg[0].kind != KIND_FAIL) && (res_buf_reg[1].kind != KIND_FAIL))
endmodule

// ===== rtl/selective_repeat_receive_window.sv =====
// Selective-repeat receive window, top level. Depends on srrw_pkg, the channel
// interfaces, srrw_ctrl and srrw_datapath. Takes one item at a time: an arrival is
// decoded, filled and then delivered; a tick reads, evaluates each slot (one slot timer
// RAM access per slot) and then delivers; the results are then transferred one by one.
// Reset clears window, counters and result count at once; no clearing pass.
module selective_repeat_receive_window #(
    parameter int unsigned WINDOW = srrw_pkg::WINDOW_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [srrw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [srrw_pkg::CFG_DATA_W-1:0]  cfg_data,
    srrw_item_if.sink                        item,
    srrw_result_if.source                    result
);
    import srrw_pkg::*;

    srrw_cmd_t    cmd;
    srrw_status_t status;
    srrw_result_t res;

    // Controller: owns the handshakes and steps the datapath through
    // dispatch, arrival decode/fill, slot scan, delivery, fail report and result transfer.
    srrw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_op     (item.operation),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: window marks, timers, retry count, configuration and the
    // two-entry result buffer that holds the results of one item.
    srrw_datapath #(
        .WINDOW (WINDOW)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_tag    (item.tag),
        .in_length (item.length),
        .cmd       (cmd),
        .status    (status),
        .res       (res)
    );

    // Present the buffered result; mark the final one of this item.
    assign result.kind        = res.kind;
    assign result.seq_number  = res.seq_number;
    assign result.request_tag = res.request_tag;
    assign result.deliver_len = res.deliver_len;
    assign result.done_res    = res.done_res;
    assign result.last        = status.out_last;
endmodule

// ===== test/tb.sv =====
// Self-checking testbench for selective_repeat_receive_window.
// Needs srrw_pkg, srrw_item_if, srrw_result_if and the RTL under rtl/.
// A scoreboard class predicts requests, deliveries and fail results per transfer.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import srrw_pkg::*;

    localparam int unsigned WIN            = WINDOW_DEFAULT;
    localparam int unsigned TAG_SPAN       = 3 * WIN;
    localparam int unsigned MAX_TAG        = 99;
    localparam int unsigned MAX_LEN        = 1398;
    localparam int unsigned RANDOM_ITEMS   = 450;
    localparam int unsigned SATURATE_TICKS = 140;
    // Worst item is a full slot scan plus two deliveries; leave margin.
    localparam int unsigned SETTLE_CYCLES  = 16;
    // Longest legal quiet stretch is a settle plus a config write plus a stall.
    localparam int unsigned QUIET_LIMIT    = 4000;
    localparam int unsigned MAX_REPORTS    = 10;

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_ARRIVE = 1'b1;

    typedef enum int unsigned {SINK_OPEN, SINK_PATTERN, SINK_RANDOM} sink_mode_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SEQ_W-1:0]  seq_number;
        logic [TAG_W-1:0]  request_tag;
        logic [LEN_W-1:0]  deliver_len;
        logic              last;
        logic              done_res;
    } window_result_t;

    // Tracks the receive window and holds the results it still owes.
    class arq_window_tracker;
        logic [SEQ_W-1:0]     pkt_total;
        logic [ELAPSED_W-1:0] wait_limit;
        logic [RETRY_W-1:0]   retry_limit;
        logic [LEN_W-1:0]     body_len;

        logic [SEQ_W-1:0]     head_seq;
        int unsigned          tag_base;
        bit                   have  [WIN];
        bit                   asked [WIN];
        logic [ELAPSED_W-1:0] age   [WIN];
        logic [RETRY_W-1:0]   tries;
        logic [LEN_W-1:0]     tail_len;
        bit                   dead;

        window_result_t       awaited[$];
        int unsigned          mismatches;
        int unsigned          n_request;
        int unsigned          n_deliver;
        int unsigned          n_fail;

        function new();
            pkt_total   = PACKET_COUNT_RESET;
            wait_limit  = TIMEOUT_RESET;
            retry_limit = MAX_RETRIES_RESET;
            body_len    = PAYLOAD_LEN_RESET;
            head_seq    = '0;
            tag_base    = 0;
            tries       = RETRY_RESET;
            tail_len    = PAYLOAD_LEN_RESET;
            dead        = 1'b0;
            for (int i = 0; i < WIN; i++) begin
                have[i]  = 1'b0;
                asked[i] = 1'b0;
                age[i]   = '0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_PACKET_COUNT:     pkt_total   = value;
                REG_TIMEOUT_TICKS:    wait_limit  = value;
                REG_MAX_RETRIES:      retry_limit = value[RETRY_W-1:0];
                REG_FULL_PAYLOAD_LEN: body_len    = value[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function window_result_t entry(logic [KIND_W-1:0] k, logic [SEQ_W-1:0] s,
                                       logic [TAG_W-1:0] t, logic [LEN_W-1:0] l, logic d);
            window_result_t r;
            r.kind        = k;
            r.seq_number  = s;
            r.request_tag = t;
            r.deliver_len = l;
            r.last        = 1'b0;
            r.done_res    = d;
            return r;
        endfunction

        function void owe_fail();
            window_result_t r;
            r = entry(KIND_FAIL, head_seq, '0, '0, 1'b0);
            r.last = 1'b1;
            awaited.push_back(r);
        endfunction

        function void accept_item(logic op, logic [TAG_W-1:0] tg, logic [LEN_W-1:0] ln);
            window_result_t batch[$];
            window_result_t tail;
            logic [SEQ_W:0]   seq;
            logic [LEN_W-1:0] dlen;
            int unsigned      off;
            if (dead) begin
                owe_fail();
                return;
            end
            if (head_seq >= pkt_total)
                return;
            if (op == OP_TICK) begin
                for (int i = 0; i < WIN; i++)
                    if (asked[i] && !have[i] && age[i] != '1)
                        age[i]++;
                for (int i = 0; i < WIN && batch.size() < MAX_RES; i++) begin
                    seq = {1'b0, head_seq} + i;
                    if (have[i] || seq >= {1'b0, pkt_total})
                        continue;
                    if (!asked[i]) begin
                        asked[i] = 1'b1;
                        age[i]   = '0;
                        tries    = RETRY_RESET;
                        batch.push_back(entry(KIND_REQUEST, seq[SEQ_W-1:0],
                                              TAG_W'((tag_base + i) % TAG_SPAN), '0, 1'b0));
                    end else if (age[i] >= wait_limit && tries <= retry_limit) begin
                        if (tries != '1)
                            tries++;
                        age[i] = '0;
                        batch.push_back(entry(KIND_REQUEST, seq[SEQ_W-1:0],
                                              TAG_W'((tag_base + i) % TAG_SPAN), '0, 1'b0));
                    end else if (tries > retry_limit) begin
                        // The failing tick drops whatever requests it already made.
                        dead = 1'b1;
                        owe_fail();
                        return;
                    end
                end
            end else begin
                off = ((tg % TAG_SPAN) + TAG_SPAN - tag_base) % TAG_SPAN;
                if (off < WIN) begin
                    seq = {1'b0, head_seq} + off;
                    if (seq < {1'b0, pkt_total}) begin
                        have[off] = 1'b1;
                        if (seq + 1 == {1'b0, pkt_total})
                            tail_len = ln;
                    end
                end
            end
            // Deliver the in-order prefix and slide the window, keeping later marks.
            while (batch.size() < MAX_RES && head_seq < pkt_total && have[0]) begin
                dlen = (head_seq == pkt_total - 1) ? tail_len : body_len;
                batch.push_back(entry(KIND_DELIVER, head_seq, '0, dlen,
                                      head_seq == pkt_total - 1));
                head_seq++;
                for (int k = 0; k + 1 < WIN; k++) begin
                    have[k]  = have[k + 1];
                    asked[k] = asked[k + 1];
                    age[k]   = age[k + 1];
                end
                have[WIN - 1]  = 1'b0;
                asked[WIN - 1] = 1'b0;
                age[WIN - 1]   = '0;
                tag_base = (tag_base + 1) % TAG_SPAN;
            end
            if (batch.size() > 0) begin
                tail = batch.pop_back();
                tail.last = 1'b1;
                batch.push_back(tail);
            end
            foreach (batch[k])
                awaited.push_back(batch[k]);
        endfunction

        function void complain(string what, window_result_t want, window_result_t got);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t %s: want kind=%0d seq=%0d tag=%0d len=%0d last=%0b done=%0b, got kind=%0d seq=%0d tag=%0d len=%0d last=%0b done=%0b",
                         $realtime, what, want.kind, want.seq_number, want.request_tag,
                         want.deliver_len, want.last, want.done_res, got.kind,
                         got.seq_number, got.request_tag, got.deliver_len, got.last,
                         got.done_res);
        endfunction

        function void check_result(window_result_t got);
            window_result_t want;
            case (got.kind)
                KIND_REQUEST: n_request++;
                KIND_DELIVER: n_deliver++;
                default:      n_fail++;
            endcase
            if (awaited.size() == 0) begin
                complain("result with nothing awaited", '0, got);
                return;
            end
            want = awaited.pop_front();
            if (got.kind !== want.kind || got.seq_number !== want.seq_number ||
                got.request_tag !== want.request_tag || got.deliver_len !== want.deliver_len ||
                got.last !== want.last || got.done_res !== want.done_res)
                complain("result mismatch", want, got);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    srrw_item_if   item_ch();
    srrw_result_if result_ch();

    arq_window_tracker tracker;

    int unsigned ticks_taken;
    int unsigned arrivals_taken;
    int unsigned quiet_cycles;

    selective_repeat_receive_window dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Result sink: switch between always-ready, a rotating stall mask and weighted random
    // draws, so stalls land at varied points of the result transfers.
    sink_mode_t  sink_mode;
    int unsigned sink_age = 0;
    logic [7:0]  sink_mask;

    always @(negedge clk)
    begin
        if (sink_age == 0) begin
            sink_age  = $urandom_range(20, 80);
            sink_mode = sink_mode_t'($urandom_range(0, 2));
            sink_mask = $urandom_range(1, 255);
        end
        sink_age--;
        sink_mask = {sink_mask[6:0], sink_mask[7]};
        case (sink_mode)
            SINK_OPEN:    result_ch.ready <= 1'b1;
            SINK_PATTERN: result_ch.ready <= sink_mask[0];
            default:      result_ch.ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Sample both channels at the rising edge; feed the tracker and run the watchdog.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (item_ch.valid && item_ch.ready) begin
                tracker.accept_item(item_ch.operation, item_ch.tag, item_ch.length);
                if (item_ch.operation == OP_TICK)
                    ticks_taken++;
                else
                    arrivals_taken++;
            end
            if (result_ch.valid && result_ch.ready)
                tracker.check_result({result_ch.kind, result_ch.seq_number,
                                      result_ch.request_tag, result_ch.deliver_len,
                                      result_ch.last, result_ch.done_res});
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: %0d cycles without a transfer, %0d results awaited",
                         quiet_cycles, tracker.awaited.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Present one item at the current falling edge and hold it until the transfer.
    task automatic present(logic op, logic [TAG_W-1:0] tg, logic [LEN_W-1:0] ln);
        item_ch.valid     <= 1'b1;
        item_ch.operation <= op;
        item_ch.tag       <= tg;
        item_ch.length    <= ln;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_fixed(logic op, logic [TAG_W-1:0] tg, logic [LEN_W-1:0] ln);
        @(negedge clk);
        present(op, tg, ln);
    endtask

    // Pick content at the falling edge, after the tracker has seen the last transfer.
    // Mostly arrivals for slots inside the window; when the shared retry count sits at
    // the limit, fill the head slot instead of ticking so random phases do not fail.
    task automatic send_random(int unsigned tick_pct);
        logic             op;
        logic [TAG_W-1:0] tg;
        logic [LEN_W-1:0] ln;
        int unsigned      roll;
        int unsigned      residue;
        bit               rescue;
        @(negedge clk);
        roll   = $urandom_range(0, 99);
        rescue = tracker.tries >= tracker.retry_limit;
        op     = (!rescue && roll < tick_pct) ? OP_TICK : OP_ARRIVE;
        residue = (tracker.tag_base + (rescue ? 0 : $urandom_range(0, WIN - 1))) % TAG_SPAN;
        tg = residue + TAG_SPAN * $urandom_range(0, (MAX_TAG - residue) / TAG_SPAN);
        if (!rescue && roll >= 92)
            tg = $urandom_range(0, MAX_TAG);
        case ($urandom_range(0, 9))
            0:       ln = '0;
            1:       ln = MAX_LEN;
            default: ln = $urandom_range(0, MAX_LEN);
        endcase
        present(op, tg, ln);
    endtask

    task automatic pause_sender(int unsigned cycles);
        @(negedge clk);
        item_ch.valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // Drop valid and hold until every awaited result has arrived; optionally let the
    // block finish an item that produced nothing before touching its registers.
    task automatic drain(bit settle);
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (tracker.awaited.size() != 0)
            @(negedge clk);
        if (settle)
            repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        tracker.write_reg(idx, value);
    endtask

    task automatic setup_transfer(logic [SEQ_W-1:0] total, logic [ELAPSED_W-1:0] wait_ticks,
                                  logic [RETRY_W-1:0] retry_max, logic [LEN_W-1:0] body);
        write_reg(REG_PACKET_COUNT, total);
        write_reg(REG_TIMEOUT_TICKS, wait_ticks);
        write_reg(REG_MAX_RETRIES, CFG_DATA_W'(retry_max));
        write_reg(REG_FULL_PAYLOAD_LEN, CFG_DATA_W'(body));
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        int unsigned      random_sent;
        int unsigned      phase_items;
        int unsigned      burst;
        int unsigned      tick_pct;
        logic [SEQ_W-1:0] total;
        logic [ELAPSED_W-1:0] wait_ticks;
        logic [RETRY_W-1:0]   retry_max;
        logic [LEN_W-1:0]     body;
        logic [TAG_W-1:0]     head_tag;
        logic [TAG_W-1:0]     next_tag;

        tracker           = new();
        random_sent       = 0;
        ticks_taken       = 0;
        arrivals_taken    = 0;
        quiet_cycles      = 0;
        rst_n             = 1'b0;
        cfg_write         = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        item_ch.valid     = 1'b0;
        item_ch.operation = OP_TICK;
        item_ch.tag       = '0;
        item_ch.length    = '0;
        result_ch.ready   = 1'b0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: with reset registers the transfer is empty, so nothing comes back.
        send_fixed(OP_TICK, '0, '0);
        send_fixed(OP_ARRIVE, '0, '0);
        drain(1);

        // Five packets, timeout of one tick, retries never exhausted, minimum body.
        setup_transfer(32'd5, 32'd1, 8'd255, 11'd1);
        send_fixed(OP_TICK, '0, '0);             // request both slots
        send_fixed(OP_TICK, '0, '0);             // both time out, request again
        send_fixed(OP_ARRIVE, 7'd99, 11'd5);     // tag outside the window
        send_fixed(OP_ARRIVE, 7'd7, 11'd100);    // fill the second slot out of order
        send_fixed(OP_ARRIVE, 7'd13, 11'd200);   // duplicate of the second slot
        send_fixed(OP_ARRIVE, 7'd0, MAX_LEN);    // fill the head, two deliveries
        send_fixed(OP_TICK, '0, '0);
        send_fixed(OP_ARRIVE, 7'd99, 11'd1);     // same residue, now inside the window
        send_fixed(OP_ARRIVE, 7'd2, '0);
        send_fixed(OP_TICK, '0, '0);             // second slot lies past the end
        send_fixed(OP_ARRIVE, 7'd5, 11'd77);     // arrival for the slot past the end
        send_fixed(OP_ARRIVE, 7'd64, 11'd1023);  // final packet sets the last length
        send_fixed(OP_TICK, '0, '0);             // transfer complete, nothing comes back

        // Random phases: each extends the transfer and draws a new register setting.
        while (random_sent < RANDOM_ITEMS) begin
            drain(1);
            case ($urandom_range(0, 9))
                0:       total = '1;
                1:       total = tracker.head_seq + 1;
                default: total = tracker.head_seq + $urandom_range(2, 30);
            endcase
            case ($urandom_range(0, 9))
                0:          wait_ticks = '1;
                1, 2, 3, 4: wait_ticks = 32'd1;
                default:    wait_ticks = $urandom_range(2, 5);
            endcase
            case ($urandom_range(0, 7))
                0:       retry_max = 8'd255;
                1:       retry_max = 8'd1;
                default: retry_max = $urandom_range(2, 20);
            endcase
            case ($urandom_range(0, 5))
                0:       body = 11'd1;
                1:       body = MAX_LEN;
                default: body = $urandom_range(1, MAX_LEN);
            endcase
            setup_transfer(total, wait_ticks, retry_max, body);
            phase_items = $urandom_range(15, 50);
            tick_pct    = $urandom_range(25, 60);
            while (phase_items > 0) begin
                burst = $urandom_range(1, 12);
                if (burst > phase_items)
                    burst = phase_items;
                repeat (burst) send_random(tick_pct);
                phase_items -= burst;
                random_sent += burst;
                // Hold the sender now and then until the block has caught up.
                case ($urandom_range(0, 19))
                    0:                   drain(0);
                    1, 2, 3, 4, 5, 6, 7: ;
                    default:             pause_sender($urandom_range(1, 6));
                endcase
            end
        end

        // Starve two slots with a one-tick timeout until the retry count saturates.
        drain(1);
        setup_transfer(tracker.head_seq + 2, 32'd1, 8'd255, 11'd700);
        repeat (SATURATE_TICKS / 10) begin
            repeat (10) send_fixed(OP_TICK, '0, '0);
            pause_sender($urandom_range(0, 4));
        end
        drain(0);
        head_tag = TAG_W'(tracker.tag_base);
        next_tag = TAG_W'((tracker.tag_base + 1) % TAG_SPAN);
        send_fixed(OP_ARRIVE, next_tag, 11'd321);
        send_fixed(OP_ARRIVE, head_tag, 11'd654);

        // Retry limit of one: the second tick re-requests the head, then fails on the
        // next slot and drops that request. Everything after that only reports failure.
        drain(1);
        setup_transfer(tracker.head_seq + 4, 32'd1, 8'd1, MAX_LEN);
        send_fixed(OP_TICK, '0, '0);
        send_fixed(OP_TICK, '0, '0);
        send_fixed(OP_ARRIVE, head_tag, 11'd9);
        send_fixed(OP_TICK, '0, '0);
        drain(1);
        setup_transfer('0, '1, 8'd0, 11'd1);
        send_fixed(OP_ARRIVE, 7'd1, 11'd1);
        send_fixed(OP_TICK, '0, '0);

        drain(1);
        $display("run covered %0d ticks and %0d arrivals; checked %0d requests, %0d deliveries, %0d fail results",
                 ticks_taken, arrivals_taken, tracker.n_request, tracker.n_deliver,
                 tracker.n_fail);
        $display("%0d mismatches, %0d results never arrived",
                 tracker.mismatches, tracker.awaited.size());
        if (tracker.mismatches == 0 && tracker.awaited.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
